@@ hdl/aos_pkg.sv @@
// Shared constants, codes, command and status types for the analog output scaler.
package aos_pkg;

    localparam int AOS_FRAC_BITS = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int DATA_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_LOW         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_HIGH        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBSTITUTE_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILURE_VALUE     = 3'd4;

    localparam logic [2:0] MODE_DISABLED = 3'd0;
    localparam logic [2:0] MODE_MA_0_20  = 3'd1;
    localparam logic [2:0] MODE_MA_4_20  = 3'd2;
    localparam logic [2:0] MODE_MA_0_24  = 3'd3;
    localparam logic [2:0] MODE_V_0_5    = 3'd4;
    localparam logic [2:0] MODE_V_0_10   = 3'd5;

    localparam logic [1:0] SRC_VALID       = 2'd0;
    localparam logic [1:0] SRC_NO_SETTINGS = 2'd1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_RANGE       = 2'd1;
    localparam logic [1:0] STATUS_NO_SETTINGS = 2'd2;
    localparam logic [1:0] STATUS_ERROR       = 2'd3;

    typedef struct packed {
        logic capture;
        logic mult;
        logic div_step;
        logic finish;
        logic check;
        logic commit;
    } aos_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_last;
    } aos_stat_t;

    function automatic logic [4:0] mode_gain(input logic [2:0] mode);
        logic [4:0] g;
        case (mode)
            MODE_MA_0_20: g = 5'd20;
            MODE_MA_4_20: g = 5'd16;
            MODE_MA_0_24: g = 5'd24;
            MODE_V_0_5:   g = 5'd5;
            MODE_V_0_10:  g = 5'd10;
            default:      g = 5'd0;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] mode_high(input logic [2:0] mode);
        logic [4:0] h;
        case (mode)
            MODE_MA_0_20: h = 5'd22;
            MODE_MA_4_20: h = 5'd22;
            MODE_MA_0_24: h = 5'd26;
            MODE_V_0_5:   h = 5'd6;
            MODE_V_0_10:  h = 5'd11;
            default:      h = 5'd0;
        endcase
        return h;
    endfunction

endpackage

@@ hdl/analog_output_scaler_core.sv @@
// Top level of the analog output scaler: controller and datapath.
// Each input transaction yields one output transaction with a Q(FRAC_BITS) setpoint and a
// status. One transaction is processed at a time. A converted sample passes in turn through
// the gain multiply, the one-bit-per-cycle restoring divider, sign, offset and saturation,
// the range check, and output. Samples with no settings, a failed source that is not passed
// on, a disabled or unused mode, or a zero span skip the divider. A finished result waits in
// the output register while the next input transaction is taken. Configuration must be
// written through cfg_write_en, cfg_index and cfg_data only while no transaction is in
// progress; the block itself does not enforce this.
module analog_output_scaler_core #(
    parameter int FRAC_BITS = aos_pkg::AOS_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [aos_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aos_pkg::DATA_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [31:0]              source_value,
    input  logic [1:0]                      source_state,
    input  logic                            source_pass_on_failure,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              out_value,
    output logic [1:0]                      status
);
    import aos_pkg::*;

    aos_cmd_t  cmd;
    aos_stat_t stat;

    aos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    aos_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_write_en           (cfg_write_en),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .source_value           (source_value),
        .source_state           (source_state),
        .source_pass_on_failure (source_pass_on_failure),
        .cmd                    (cmd),
        .stat                   (stat),
        .out_value              (out_value),
        .status                 (status)
    );

endmodule

@@ hdl/aos_ctrl.sv @@
// Controller state machine that sequences one transaction through the datapath.
module aos_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output aos_pkg::aos_cmd_t cmd,
    input  aos_pkg::aos_stat_t stat
);
    import aos_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MULT  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_FIX   = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_commit;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign can_commit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (stat.skip)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mult   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.finish = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (can_commit)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result must never overwrite one that is still waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("commit while output transaction is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit did not raise out_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && stat.div_last) |=> (state_reg == ST_FIX))
        else $error("divider finished without moving to fix-up");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while busy");

endmodule

@@ hdl/aos_dpath.sv @@
// Datapath: configuration registers, scaling multiplier, restoring divider and range check.
module aos_dpath #(
    parameter int FRAC_BITS = aos_pkg::AOS_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [aos_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aos_pkg::DATA_W-1:0]         cfg_data,
    input  logic signed [31:0]                 source_value,
    input  logic [1:0]                         source_state,
    input  logic                               source_pass_on_failure,
    input  aos_pkg::aos_cmd_t                  cmd,
    output aos_pkg::aos_stat_t                 stat,
    output logic signed [31:0]                 out_value,
    output logic [1:0]                         status
);
    import aos_pkg::*;

    localparam int QW = 37 + FRAC_BITS;
    localparam int VW = QW + 2;
    localparam int CW = $clog2(QW);
    localparam logic [31:0] LO_4_20 = 32'(((36 << FRAC_BITS) + 5) / 10);
    localparam logic [VW-1:0] OFFSET_4 = VW'(4) << FRAC_BITS;
    localparam logic signed [VW-1:0] SAT_MAX = {{(VW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [VW-1:0] SAT_MIN = {{(VW-31){1'b1}}, {31{1'b0}}};

    logic [2:0]  output_mode_reg;
    logic [31:0] scale_low_reg;
    logic [31:0] scale_high_reg;
    logic        substitute_enable_reg;
    logic [31:0] failure_value_reg;
    logic [31:0] held_reg;

    logic [2:0]    mode_reg;
    logic [32:0]   diff_reg;
    logic [32:0]   span_reg;
    logic          skip_reg;
    logic          neg_reg;
    logic [32:0]   divisor_reg;
    logic [32:0]   rem_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   res_val_reg;
    logic [1:0]    res_status_reg;
    logic [31:0]   out_value_reg;
    logic [1:0]    status_reg;

    logic          convert;
    logic [4:0]    gain_in;
    logic [4:0]    gain;
    logic [32:0]   mdiff;
    logic [32:0]   mspan;
    logic [37:0]   product;
    logic [33:0]   trial;
    logic          fits;
    logic [VW-1:0] qext;
    logic signed [VW-1:0] scaled;
    logic [31:0]   lo_lim;
    logic [31:0]   hi_lim;

    assign convert = (source_state == SRC_VALID)
                  || ((source_state != SRC_NO_SETTINGS) && source_pass_on_failure);
    assign gain_in = mode_gain(output_mode_reg);
    assign gain    = mode_gain(mode_reg);
    assign mdiff   = diff_reg[32] ? 33'(~diff_reg + 33'd1) : diff_reg;
    assign mspan   = span_reg[32] ? 33'(~span_reg + 33'd1) : span_reg;
    assign product = mdiff * gain;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    assign qext   = {2'b00, quo_reg};
    assign scaled = $signed((neg_reg ? VW'(~qext + VW'(1)) : qext)
                  + ((mode_reg == MODE_MA_4_20) ? OFFSET_4 : VW'(0)));

    assign lo_lim = (mode_reg == MODE_MA_4_20) ? LO_4_20 : 32'd0;
    assign hi_lim = {27'd0, mode_high(mode_reg)} << FRAC_BITS;

    assign stat.skip     = skip_reg;
    assign stat.div_last = (count_reg == CW'(0));
    assign out_value     = out_value_reg;
    assign status        = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg       <= MODE_DISABLED;
            scale_low_reg         <= 32'd0;
            scale_high_reg        <= 32'd1 << FRAC_BITS;
            substitute_enable_reg <= 1'b0;
            failure_value_reg     <= 32'd0;
            held_reg              <= 32'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_OUTPUT_MODE:       output_mode_reg       <= cfg_data[2:0];
                    CFG_SCALE_LOW:         scale_low_reg         <= cfg_data;
                    CFG_SCALE_HIGH:        scale_high_reg        <= cfg_data;
                    CFG_SUBSTITUTE_ENABLE: substitute_enable_reg <= cfg_data[0];
                    CFG_FAILURE_VALUE:     failure_value_reg     <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.commit)
            begin
                held_reg <= res_val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= output_mode_reg;
            diff_reg <= {source_value[31], source_value} - {scale_low_reg[31], scale_low_reg};
            span_reg <= {scale_high_reg[31], scale_high_reg}
                      - {scale_low_reg[31], scale_low_reg};
            skip_reg <= 1'b1;
            if (source_state == SRC_NO_SETTINGS)
            begin
                res_val_reg    <= held_reg;
                res_status_reg <= STATUS_NO_SETTINGS;
            end
            else if (convert && (gain_in == 5'd0))
            begin
                res_val_reg    <= 32'd0;
                res_status_reg <= STATUS_OK;
            end
            else if (convert && (scale_high_reg == scale_low_reg))
            begin
                res_val_reg    <= 32'd0;
                res_status_reg <= STATUS_RANGE;
            end
            else if (convert)
            begin
                skip_reg <= 1'b0;
            end
            else if (substitute_enable_reg)
            begin
                res_val_reg    <= failure_value_reg;
                res_status_reg <= STATUS_OK;
            end
            else
            begin
                res_val_reg    <= 32'd0;
                res_status_reg <= STATUS_ERROR;
            end
        end
        if (cmd.mult)
        begin
            neg_reg     <= diff_reg[32] ^ span_reg[32];
            divisor_reg <= mspan;
            rem_reg     <= 33'd0;
            quo_reg     <= {product[36:0], {FRAC_BITS{1'b0}}};
            count_reg   <= CW'(QW - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg   <= fits ? 33'(trial - {1'b0, divisor_reg}) : trial[32:0];
            quo_reg   <= {quo_reg[QW-2:0], fits};
            count_reg <= count_reg - CW'(1);
        end
        if (cmd.finish)
        begin
            if (scaled > SAT_MAX)
            begin
                res_val_reg <= 32'h7FFF_FFFF;
            end
            else if (scaled < SAT_MIN)
            begin
                res_val_reg <= 32'h8000_0000;
            end
            else
            begin
                res_val_reg <= scaled[31:0];
            end
        end
        if (cmd.check)
        begin
            res_status_reg <= (($signed(res_val_reg) >= $signed(lo_lim))
                            && ($signed(res_val_reg) <= $signed(hi_lim)))
                            ? STATUS_OK : STATUS_RANGE;
        end
        if (cmd.commit)
        begin
            out_value_reg <= res_val_reg;
            status_reg    <= res_status_reg;
        end
    end

endmodule

@@ tb/sv/tb_analog_output_scaler_core.sv @@
// Self-checking testbench for analog_output_scaler_core: directed table, then random samples.
module tb_analog_output_scaler_core;
    import aos_pkg::*;

    localparam logic [1:0] SRC_FAILED    = 2'd2;
    localparam logic [1:0] SRC_UNDEFINED = 2'd3;
    localparam logic [2:0] MODE_SPARE_6  = 3'd6;
    localparam logic [2:0] MODE_SPARE_7  = 3'd7;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF;
    localparam longint SAT_MIN = -64'sh8000_0000;

    localparam int RANDOM_PHASES = 3;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 77;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 100;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } setpoint_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [DATA_W-1:0]      reg_data;
        logic [31:0]            src;
        logic [1:0]             state;
        logic                   pass;
        logic                   typed;
        logic [31:0]            exp_value;
        logic [1:0]             exp_status;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 40;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{ROW_ITEM, '0, '0, 32'h7FFF_FFFF, SRC_VALID, 1'b0, 1'b1, 32'h0, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h8000_0000, SRC_FAILED, 1'b1, 1'b1, 32'h0, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h1234_5678, SRC_NO_SETTINGS, 1'b1, 1'b1, 32'h0,
            STATUS_NO_SETTINGS},
        '{ROW_ITEM, '0, '0, 32'h0005_0000, SRC_FAILED, 1'b0, 1'b1, 32'h0, STATUS_ERROR},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_MA_0_20), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0000_8000, SRC_VALID, 1'b0, 1'b1, 32'h000A_0000, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h0001_0000, SRC_VALID, 1'b0, 1'b1, 32'h0014_0000, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h7FFF_FFFF, SRC_VALID, 1'b0, 1'b1, 32'h7FFF_FFFF, STATUS_RANGE},
        '{ROW_ITEM, '0, '0, 32'h8000_0000, SRC_VALID, 1'b1, 1'b1, 32'h8000_0000, STATUS_RANGE},
        '{ROW_ITEM, '0, '0, 32'h0000_0000, SRC_NO_SETTINGS, 1'b0, 1'b1, 32'h8000_0000,
            STATUS_NO_SETTINGS},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_MA_4_20), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0000_0000, SRC_VALID, 1'b0, 1'b1, 32'h0004_0000, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h0001_0000, SRC_VALID, 1'b0, 1'b1, 32'h0014_0000, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'hFFFF_0000, SRC_VALID, 1'b0, 1'b1, 32'hFFF4_0000, STATUS_RANGE},
        '{ROW_ITEM, '0, '0, 32'hFFFF_F99A, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'hFFFF_F999, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0001_2000, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_MA_0_24), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0000_0001, SRC_FAILED, 1'b0, 1'b1, 32'h0, STATUS_ERROR},
        '{ROW_WRITE, CFG_SUBSTITUTE_ENABLE, DATA_W'(1'b1), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_FAILURE_VALUE, 32'h7FFF_FFFF, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0000_0001, SRC_FAILED, 1'b0, 1'b1, 32'h7FFF_FFFF, STATUS_OK},
        '{ROW_WRITE, CFG_FAILURE_VALUE, 32'h8000_0000, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'hFFFF_FFFF, SRC_UNDEFINED, 1'b0, 1'b1, 32'h8000_0000, STATUS_OK},
        '{ROW_WRITE, CFG_SCALE_HIGH, 32'h0000_0000, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0001_0000, SRC_VALID, 1'b0, 1'b1, 32'h0, STATUS_RANGE},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_V_0_5), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SCALE_LOW, 32'h8000_0000, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SCALE_HIGH, 32'h7FFF_FFFF, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h7FFF_FFFF, SRC_VALID, 1'b0, 1'b1, 32'h0005_0000, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h8000_0000, SRC_VALID, 1'b0, 1'b1, 32'h0, STATUS_OK},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_V_0_10), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SCALE_LOW, 32'h7FFF_FFFF, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SCALE_HIGH, 32'h8000_0000, '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h8000_0000, SRC_VALID, 1'b0, 1'b1, 32'h000A_0000, STATUS_OK},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_SPARE_6), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h7FFF_FFFF, SRC_VALID, 1'b0, 1'b1, 32'h0, STATUS_OK},
        '{ROW_WRITE, CFG_OUTPUT_MODE, DATA_W'(MODE_SPARE_7), '0, SRC_VALID, 1'b0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 32'h0000_0000, SRC_FAILED, 1'b1, 1'b1, 32'h0, STATUS_OK},
        '{ROW_ITEM, '0, '0, 32'h0000_0000, SRC_NO_SETTINGS, 1'b0, 1'b1, 32'h0,
            STATUS_NO_SETTINGS}
    };

    logic                   clk;
    logic                   rst_n                  = 1'b0;
    logic                   cfg_write_en           = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index              = '0;
    logic [DATA_W-1:0]      cfg_data               = '0;
    logic                   in_valid               = 1'b0;
    logic                   in_stall;
    logic signed [31:0]     source_value           = '0;
    logic [1:0]             source_state           = '0;
    logic                   source_pass_on_failure = 1'b0;
    logic                   out_valid;
    logic                   out_stall              = 1'b0;
    logic signed [31:0]     out_value;
    logic [1:0]             status;

    logic                   row_typed  = 1'b0;
    logic [31:0]            row_value  = '0;
    logic [1:0]             row_status = '0;

    logic [2:0]             scaler_mode       = MODE_DISABLED;
    logic [31:0]            scaler_low        = '0;
    logic [31:0]            scaler_high       = 32'd1 << AOS_FRAC_BITS;
    logic                   scaler_subst      = 1'b0;
    logic [31:0]            scaler_fail_value = '0;
    logic [31:0]            scaler_held       = '0;

    setpoint_t              setpoint_q[$];
    int                     mismatch_count = 0;
    int unsigned            tx_idle_pct    = 29;
    int unsigned            rx_idle_pct    = 50;

    analog_output_scaler_core #(
        .FRAC_BITS(AOS_FRAC_BITS)
    ) i_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_write_en           (cfg_write_en),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .source_value           (source_value),
        .source_state           (source_state),
        .source_pass_on_failure (source_pass_on_failure),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .out_value              (out_value),
        .status                 (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic setpoint_t convert_sample(input logic signed [31:0] src);
        setpoint_t            r;
        longint               diff;
        longint               span;
        longint               v;
        longint               lo_lim;
        longint               hi_lim;
        longint unsigned      mdiff;
        longint unsigned      mspan;
        longint unsigned      quot;
        longint unsigned      gain;
        longint unsigned      top;
        logic                 neg;
        case (scaler_mode)
            MODE_MA_0_20:
            begin
                gain = 20;
                top  = 22;
            end
            MODE_MA_4_20:
            begin
                gain = 16;
                top  = 22;
            end
            MODE_MA_0_24:
            begin
                gain = 24;
                top  = 26;
            end
            MODE_V_0_5:
            begin
                gain = 5;
                top  = 6;
            end
            MODE_V_0_10:
            begin
                gain = 10;
                top  = 11;
            end
            default:
            begin
                gain = 0;
                top  = 0;
            end
        endcase
        diff = longint'(src) - longint'($signed(scaler_low));
        span = longint'($signed(scaler_high)) - longint'($signed(scaler_low));
        r.value  = '0;
        r.status = STATUS_OK;
        if (gain != 0 && span == 0)
        begin
            r.status = STATUS_RANGE;
        end
        else if (gain != 0)
        begin
            neg   = (diff < 0) ^ (span < 0);
            mdiff = (diff < 0) ? -diff : diff;
            mspan = (span < 0) ? -span : span;
            quot  = ((mdiff * gain) << AOS_FRAC_BITS) / mspan;
            v     = neg ? -longint'(quot) : longint'(quot);
            lo_lim = 0;
            if (scaler_mode == MODE_MA_4_20)
            begin
                v      = v + (longint'(4) << AOS_FRAC_BITS);
                lo_lim = ((longint'(36) << AOS_FRAC_BITS) + 5) / 10;
            end
            hi_lim = longint'(top) << AOS_FRAC_BITS;
            if (v > SAT_MAX)
                v = SAT_MAX;
            else if (v < SAT_MIN)
                v = SAT_MIN;
            r.value  = v[31:0];
            r.status = (v >= lo_lim && v <= hi_lim) ? STATUS_OK : STATUS_RANGE;
        end
        return r;
    endfunction

    function automatic setpoint_t next_setpoint(input logic [31:0] src, input logic [1:0] state,
                                                input logic pass);
        setpoint_t r;
        if (state == SRC_NO_SETTINGS)
        begin
            r.value  = scaler_held;
            r.status = STATUS_NO_SETTINGS;
        end
        else
        begin
            if (state == SRC_VALID || pass)
                r = convert_sample(src);
            else if (scaler_subst)
                r = '{scaler_fail_value, STATUS_OK};
            else
                r = '{32'h0, STATUS_ERROR};
            scaler_held = r.value;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        setpoint_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (setpoint_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Unexpected result transaction: value %h status %0d",
                                 out_value, status);
                end
                else
                begin
                    want = setpoint_q.pop_front();
                    if (out_value !== want.value || status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("Mismatch: expected value %h status %0d, got value %h status %0d",
                                     want.value, want.status, out_value, status);
                    end
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_OUTPUT_MODE:       scaler_mode       = cfg_data[2:0];
                    CFG_SCALE_LOW:         scaler_low        = cfg_data;
                    CFG_SCALE_HIGH:        scaler_high       = cfg_data;
                    CFG_SUBSTITUTE_ENABLE: scaler_subst      = cfg_data[0];
                    CFG_FAILURE_VALUE:     scaler_fail_value = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want = next_setpoint(source_value, source_state, source_pass_on_failure);
                if (row_typed)
                    want = '{row_value, row_status};
                setpoint_q.push_back(want);
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    task automatic drive_sample(input logic [31:0] src, input logic [1:0] state,
                                input logic pass, input logic typed,
                                input logic [31:0] exp_value, input logic [1:0] exp_status);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid               <= 1'b1;
        source_value           <= src;
        source_state           <= state;
        source_pass_on_failure <= pass;
        row_typed              <= typed;
        row_value              <= exp_value;
        row_status             <= exp_status;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The first edge lets the scoreboard record a transaction accepted at the current edge.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic load_random_settings();
        longint      lo;
        longint      span;
        longint      hi;
        logic [31:0] lo32;
        logic [31:0] hi32;
        logic [31:0] fail32;
        logic [2:0]  mode;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            mode = 3'(1 + sel % 5);
        else
            mode = 3'($urandom_range(0, 7));
        lo   = (longint'($urandom_range(0, 400)) - 200) * (longint'(1) << AOS_FRAC_BITS)
               + longint'($urandom_range(0, 65535));
        span = longint'($urandom_range(1, 65535)) << $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            span = -span;
        hi   = lo + span;
        lo32 = lo[31:0];
        hi32 = hi[31:0];
        case ($urandom_range(0, 9))
            6:
            begin
                lo32 = $urandom;
                hi32 = $urandom;
            end
            7:
            begin
                lo32 = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                hi32 = ($urandom_range(0, 2) == 0) ? lo32 : ~lo32;
            end
            8: hi32 = lo32;
            9: hi32 = lo32 + 32'd1;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: fail32 = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: fail32 = $urandom;
        endcase
        write_register(CFG_OUTPUT_MODE, DATA_W'(mode));
        write_register(CFG_SCALE_LOW, lo32);
        write_register(CFG_SCALE_HIGH, hi32);
        write_register(CFG_SUBSTITUTE_ENABLE, DATA_W'($urandom_range(0, 1)));
        write_register(CFG_FAILURE_VALUE, fail32);
    endtask

    function automatic logic [31:0] pick_source();
        longint      lo;
        longint      hi;
        longint      v;
        int unsigned sel;
        lo  = longint'($signed(scaler_low));
        hi  = longint'($signed(scaler_high));
        sel = $urandom_range(0, 9);
        if (sel < 7)
            v = lo + (hi - lo) * (longint'($urandom_range(0, 1200)) - 100) / 1000;
        else if (sel == 7)
            v = longint'($urandom);
        else if (sel == 8)
        begin
            case ($urandom_range(0, 3))
                0: v = SAT_MIN;
                1: v = SAT_MAX;
                2: v = 0;
                default: v = -1;
            endcase
        end
        else
            v = lo + longint'($urandom_range(0, 2000)) - 1000;
        return v[31:0];
    endfunction

    function automatic logic [1:0] pick_state();
        int unsigned r;
        logic [1:0]  state;
        r = $urandom_range(0, 99);
        if (r < 60)
            state = SRC_VALID;
        else if (r < 72)
            state = SRC_NO_SETTINGS;
        else if (r < 92)
            state = SRC_FAILED;
        else
            state = SRC_UNDEFINED;
        return state;
    endfunction

    initial
    begin
        stim_row_t row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_until_idle();
                write_register(row.reg_index, row.reg_data);
            end
            else
                drive_sample(row.src, row.state, row.pass, row.typed, row.exp_value,
                             row.exp_status);
        end
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 50;
                end
                1:
                begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 29;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                wait_until_idle();
                load_random_settings();
                repeat (SEGMENT_ITEMS)
                    drive_sample(pick_source(), pick_state(), 1'($urandom_range(0, 1)),
                                 1'b0, '0, '0);
            end
        end
        in_valid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && setpoint_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
